// File: sv/dqd_pkg.sv
// Shared types and constants of the deque with indexed delete.
package dqd_pkg;

    localparam int REQ_W   = 2;
    localparam int POS_W   = 4;
    localparam int DATA_W  = 32;

    typedef enum logic [REQ_W-1:0] {
        REQ_PUSH_FRONT = 2'd0,
        REQ_PUSH_BACK  = 2'd1,
        REQ_DELETE     = 2'd2,
        REQ_NOP        = 2'd3
    } t_req;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SHIFT,
        ST_DSTART,
        ST_DUMP,
        ST_EMPTY
    } t_state;

endpackage

// File: sv/dqd_if.sv
// Handshake channels for requests into and dump beats out of the deque.
interface dqd_req_if
    import dqd_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic [REQ_W-1:0]         req_type;
    logic signed [DATA_W-1:0] item_value;
    logic [POS_W-1:0]         position;

    modport source (output valid, req_type, item_value, position, input ready);
    modport sink   (input valid, req_type, item_value, position, output ready);
endinterface

interface dqd_dump_if
    import dqd_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] entry_value;
    logic                     backward;
    logic                     is_last;
    logic                     list_empty;
    logic                     push_rejected;

    modport source (output valid, entry_value, backward, is_last, list_empty, push_rejected,
                    input ready);
    modport sink   (input valid, entry_value, backward, is_last, list_empty, push_rejected,
                    output ready);
endinterface

// File: sv/deque_indexed_delete_dump_unit.sv
// Deque with indexed delete: a bounded double-ended list in a ring memory that dumps its
// contents after every request. A request is taken in the cycle in which a push writes the
// memory and the pointers move. A delete in the middle of the list then moves each later
// entry one place toward the front through the memory's read and write ports, one entry per
// cycle in a read-ahead pipeline. ST_DSTART then starts the first memory read, after which
// the dump streams one beat per cycle while the sink takes them: 2 * count beats front to
// back and back again, or a single beat marked empty. The next request is taken once the
// last beat sits in the output register, even while that beat still waits for the sink.
// There is no clearing pass after reset: only written entries are ever read.
module deque_indexed_delete_dump_unit
    import dqd_pkg::*;
#(
    parameter int CAPACITY   = 16,
    parameter int VALUE_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    dqd_req_if.sink     i_req,
    dqd_dump_if.source  o_dump
);

    localparam int PTR_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    // Ring slot of the entry that lies off places behind the front.
    function automatic logic [PTR_W-1:0] f_slot(input logic [PTR_W-1:0] base,
                                                input logic [CNT_W-1:0] off);
        logic [CNT_W:0] sum;
        sum = (CNT_W+1)'(base) + (CNT_W+1)'(off);
        if (sum >= (CNT_W+1)'(CAPACITY)) begin
            sum = sum - (CNT_W+1)'(CAPACITY);
        end
        return PTR_W'(sum);
    endfunction

    // Entry memory and its registered read port.
    logic [VALUE_BITS-1:0] r_mem [CAPACITY];
    logic [VALUE_BITS-1:0] r_rd_data;

    t_state             r_state, n_state;
    logic [PTR_W-1:0]   r_front, n_front;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [CNT_W-1:0]   r_idx, n_idx;
    logic               r_back, n_back;
    logic               r_rej, n_rej;
    logic               r_wr_pend, n_wr_pend;
    logic [PTR_W-1:0]   r_wr_addr, n_wr_addr;

    // Output register that parts the dump from the sink.
    logic                     r_out_valid, n_out_valid;
    logic signed [DATA_W-1:0] r_out_value, n_out_value;
    logic                     r_out_back, n_out_back;
    logic                     r_out_last, n_out_last;
    logic                     r_out_empty, n_out_empty;
    logic                     r_out_rej, n_out_rej;

    logic                  w_accept;
    logic                  w_can_load;
    logic                  w_rd_en;
    logic [PTR_W-1:0]      w_rd_addr;
    logic                  w_we;
    logic [PTR_W-1:0]      w_wr_addr;
    logic [VALUE_BITS-1:0] w_wr_data;
    logic signed [63:0]    w_ext;

    // Request decode.
    t_req               w_req;
    logic               w_full;
    logic               w_push;
    logic               w_del_ok;
    logic               w_del_front;
    logic               w_del_mid;
    logic [CMP_W-1:0]   w_pos_x;
    logic [CMP_W-1:0]   w_cnt_x;
    logic [PTR_W-1:0]   w_front_dec;
    logic [CNT_W-1:0]   w_new_count;

    assign i_req.ready = (r_state == ST_IDLE);
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_can_load  = !r_out_valid || o_dump.ready;

    // Stored values are sign-extended from their own width to the result width.
    assign w_ext = 64'(signed'(r_rd_data));

    always_comb begin
        w_req       = t_req'(i_req.req_type);
        w_full      = (r_count == CNT_W'(CAPACITY));
        w_push      = (w_req == REQ_PUSH_FRONT) || (w_req == REQ_PUSH_BACK);
        w_pos_x     = CMP_W'(i_req.position);
        w_cnt_x     = CMP_W'(r_count);
        w_del_ok    = (w_req == REQ_DELETE) && (w_pos_x < w_cnt_x);
        w_del_front = w_del_ok && (w_pos_x == '0);
        // A middle delete has entries on both sides of the removed one.
        w_del_mid   = w_del_ok && (w_pos_x != '0) && (w_pos_x + CMP_W'(1) < w_cnt_x);
        w_front_dec = (r_front == '0) ? PTR_W'(CAPACITY - 1) : r_front - PTR_W'(1);
        if (w_push && !w_full) begin
            w_new_count = r_count + CNT_W'(1);
        end else if (w_del_ok) begin
            w_new_count = r_count - CNT_W'(1);
        end else begin
            w_new_count = r_count;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (w_new_count == '0) begin
                        n_state = ST_EMPTY;
                    end else if (w_del_mid) begin
                        n_state = ST_SHIFT;
                    end else begin
                        n_state = ST_DSTART;
                    end
                end
            end
            ST_SHIFT: begin
                if (r_idx == r_count) begin
                    n_state = ST_DSTART;
                end
            end
            ST_DSTART: begin
                n_state = ST_DUMP;
            end
            ST_DUMP: begin
                if (w_can_load && r_back && (r_idx == '0)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_EMPTY: begin
                if (w_can_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Datapath, memory controls and output register loads.
    always_comb begin
        n_front     = r_front;
        n_count     = r_count;
        n_idx       = r_idx;
        n_back      = r_back;
        n_rej       = r_rej;
        n_wr_pend   = 1'b0;
        n_wr_addr   = r_wr_addr;
        w_rd_en     = 1'b0;
        w_rd_addr   = r_front;
        w_we        = r_wr_pend;
        w_wr_addr   = r_wr_addr;
        w_wr_data   = r_rd_data;
        n_out_valid = r_out_valid && !o_dump.ready;
        n_out_value = r_out_value;
        n_out_back  = r_out_back;
        n_out_last  = r_out_last;
        n_out_empty = r_out_empty;
        n_out_rej   = r_out_rej;

        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_rej   = w_push && w_full;
                    n_count = w_new_count;
                    if (w_push && !w_full) begin
                        w_we      = 1'b1;
                        w_wr_data = VALUE_BITS'({32'd0, i_req.item_value});
                        if (w_req == REQ_PUSH_FRONT) begin
                            n_front   = w_front_dec;
                            w_wr_addr = w_front_dec;
                        end else begin
                            w_wr_addr = f_slot(r_front, r_count);
                        end
                    end
                    if (w_del_front) begin
                        n_front = f_slot(r_front, CNT_W'(1));
                    end
                    // The shift reads from the entry just behind the removed one.
                    n_idx = CNT_W'(w_pos_x + CMP_W'(1));
                end
            end
            ST_SHIFT: begin
                // Read entry idx now; it lands one place nearer the front next cycle.
                w_rd_en   = 1'b1;
                w_rd_addr = f_slot(r_front, r_idx);
                n_wr_pend = 1'b1;
                n_wr_addr = f_slot(r_front, r_idx - CNT_W'(1));
                n_idx     = r_idx + CNT_W'(1);
            end
            ST_DSTART: begin
                w_rd_en   = 1'b1;
                w_rd_addr = r_front;
                n_idx     = '0;
                n_back    = 1'b0;
            end
            ST_DUMP: begin
                if (w_can_load) begin
                    n_out_valid = 1'b1;
                    n_out_value = w_ext[DATA_W-1:0];
                    n_out_back  = r_back;
                    n_out_last  = r_back && (r_idx == '0);
                    n_out_empty = 1'b0;
                    n_out_rej   = r_rej;
                    if (!r_back) begin
                        if (r_idx == r_count - CNT_W'(1)) begin
                            n_back = 1'b1;
                        end else begin
                            n_idx = r_idx + CNT_W'(1);
                        end
                    end else begin
                        n_idx = r_idx - CNT_W'(1);
                    end
                    // Fetch the next entry unless the final beat just went out.
                    if (!(r_back && (r_idx == '0))) begin
                        w_rd_en   = 1'b1;
                        w_rd_addr = f_slot(r_front, n_idx);
                    end
                end
            end
            ST_EMPTY: begin
                if (w_can_load) begin
                    n_out_valid = 1'b1;
                    n_out_value = '0;
                    n_out_back  = 1'b0;
                    n_out_last  = 1'b1;
                    n_out_empty = 1'b1;
                    n_out_rej   = r_rej;
                end
            end
            default: begin
                n_wr_pend = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
        if (w_rd_en) begin
            r_rd_data <= r_mem[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_front     <= '0;
            r_count     <= '0;
            r_wr_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_front     <= n_front;
            r_count     <= n_count;
            r_wr_pend   <= n_wr_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx       <= n_idx;
        r_back      <= n_back;
        r_rej       <= n_rej;
        r_wr_addr   <= n_wr_addr;
        r_out_value <= n_out_value;
        r_out_back  <= n_out_back;
        r_out_last  <= n_out_last;
        r_out_empty <= n_out_empty;
        r_out_rej   <= n_out_rej;
    end

    assign o_dump.valid         = r_out_valid;
    assign o_dump.entry_value   = r_out_value;
    assign o_dump.backward      = r_out_back;
    assign o_dump.is_last       = r_out_last;
    assign o_dump.list_empty    = r_out_empty;
    assign o_dump.push_rejected = r_out_rej;

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench of the deque with indexed delete and its contents dump.
module testbench;
    import dqd_pkg::*;

    // The block is built with its default geometry. The mirror below uses the same numbers.
    localparam int CAPACITY   = 16;
    localparam int CLK_PERIOD = 4;
    localparam int RESET_CYCLES = 6;

    // The tail wait after the last expected beat covers the block's longest request, so that
    // a stray extra beat still shows up.
    localparam int TAIL_CYCLES = 3 * CAPACITY + 8;

    // The watchdog counts cycles in which neither channel moves a beat. In a correct run the
    // longest such stretch is a middle delete's shift plus a random sender gap or sink stall
    // at 66 percent. The limit sits far above both.
    localparam int STALL_LIMIT = 4000;

    // Random requests per idling phase. With the directed part this gives about 460 requests.
    localparam int RANDOM_PER_PHASE = 108;

    localparam logic signed [DATA_W-1:0] VAL_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] VAL_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    // One dump beat, as the sink sees it.
    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     backward;
        logic                     is_last;
        logic                     list_empty;
        logic                     push_rejected;
    } t_dump_beat;

    // Mirror of the deque. It keeps its own ring, front index and fill count, works out the
    // dump that each accepted request must produce, and checks the beats against that queue.
    class t_deque_mirror;
        logic signed [DATA_W-1:0] ring [CAPACITY];
        int                       head;
        int                       fill;
        t_dump_beat               expected_beats [$];

        // Run statistics for the closing summary.
        int requests;
        int rejected_pushes;
        int ignored_deletes;
        int middle_deletes;
        int peak_fill;
        int beats_checked;
        int mismatches;

        function new();
            head = 0;
            fill = 0;
            foreach (ring[i]) ring[i] = '0;
        endfunction

        function int slot_of(int index);
            return (head + index) % CAPACITY;
        endfunction

        task report(string what);
            mismatches++;
            $display("[%0t] MISMATCH: %s", $time, what);
        endtask

        // Applies one accepted request to the mirror and queues the dump that follows it.
        function void note_request(t_req kind, logic signed [DATA_W-1:0] value,
                                   logic [POS_W-1:0] pos);
            logic       rejected;
            t_dump_beat beat;
            rejected = 1'b0;
            requests++;
            case (kind)
                REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
                    if (fill >= CAPACITY) begin
                        // A full list drops the value; every beat of this dump is flagged.
                        rejected = 1'b1;
                        rejected_pushes++;
                    end else if (kind == REQ_PUSH_FRONT) begin
                        head = (head + CAPACITY - 1) % CAPACITY;
                        ring[head] = value;
                        fill++;
                    end else begin
                        ring[slot_of(fill)] = value;
                        fill++;
                    end
                end
                REQ_DELETE: begin
                    if (int'(pos) >= fill) begin
                        // Covers both the empty list and a position past the back.
                        ignored_deletes++;
                    end else begin
                        if (pos == 0) begin
                            head = (head + 1) % CAPACITY;
                        end else begin
                            if (int'(pos) < fill - 1) middle_deletes++;
                            // Close the gap: later entries move one place toward the front.
                            // At the back position the loop has nothing to move.
                            for (int i = int'(pos); i + 1 < fill; i++) begin
                                ring[slot_of(i)] = ring[slot_of(i + 1)];
                            end
                        end
                        fill--;
                    end
                end
                default: ;
            endcase
            if (fill > peak_fill) peak_fill = fill;

            beat.push_rejected = rejected;
            beat.list_empty    = 1'b0;
            if (fill == 0) begin
                beat.value      = '0;
                beat.backward   = 1'b0;
                beat.is_last    = 1'b1;
                beat.list_empty = 1'b1;
                expected_beats.insert(expected_beats.size(), beat);
                return;
            end
            beat.backward = 1'b0;
            beat.is_last  = 1'b0;
            for (int i = 0; i < fill; i++) begin
                beat.value = ring[slot_of(i)];
                expected_beats.insert(expected_beats.size(), beat);
            end
            beat.backward = 1'b1;
            for (int i = fill - 1; i >= 0; i--) begin
                beat.value   = ring[slot_of(i)];
                beat.is_last = (i == 0);
                expected_beats.insert(expected_beats.size(), beat);
            end
        endfunction

        // Compares one accepted dump beat with the oldest expectation.
        task check_beat(t_dump_beat got);
            t_dump_beat want;
            logic       bad;
            beats_checked++;
            if (expected_beats.size() == 0) begin
                report($sformatf(
                    "unexpected dump beat: value %0d back %0b last %0b empty %0b rej %0b",
                    got.value, got.backward, got.is_last, got.list_empty,
                    got.push_rejected));
                return;
            end
            want = expected_beats[0];
            expected_beats.delete(0);
            bad = (got.backward !== want.backward) || (got.is_last !== want.is_last) ||
                  (got.list_empty !== want.list_empty) ||
                  (got.push_rejected !== want.push_rejected);
            // The value carries no meaning on the beat of an empty list.
            if (!want.list_empty && got.value !== want.value) bad = 1'b1;
            if (bad) begin
                report({$sformatf(
                            "beat %0d expected value %0d back %0b last %0b empty %0b rej %0b, ",
                            beats_checked, want.value, want.backward, want.is_last,
                            want.list_empty, want.push_rejected),
                        $sformatf("got value %0d back %0b last %0b empty %0b rej %0b",
                                  got.value, got.backward, got.is_last, got.list_empty,
                                  got.push_rejected)});
            end
        endtask
    endclass

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    dqd_req_if  req_if ();
    dqd_dump_if dump_if ();

    t_deque_mirror book;

    // Idling percentages of the current phase, read by the request driver and the sink.
    int sender_idle_pct;
    int sink_stall_pct;
    int quiet_cycles;

    // Random requests lean toward growth or toward shrinkage, so that the list spends long
    // stretches near full and near empty.
    bit growing;

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    deque_indexed_delete_dump_unit #(
        .CAPACITY   (CAPACITY),
        .VALUE_BITS (DATA_W)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_dump  (dump_if)
    );

    // Sink side. Handshake signals are sampled right after the edge, so they still hold the
    // values that the edge saw. Ready is then redrawn for the next cycle.
    always @(posedge i_clk) begin
        if (i_rst_n && dump_if.valid && dump_if.ready) begin
            book.check_beat({dump_if.entry_value, dump_if.backward, dump_if.is_last,
                             dump_if.list_empty, dump_if.push_rejected});
        end
        dump_if.ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // Watchdog: any beat on either channel resets the count of quiet cycles.
    always @(posedge i_clk) begin
        if (!i_rst_n || (req_if.valid && req_if.ready) || (dump_if.valid && dump_if.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("deque_indexed_delete_dump_unit regression: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offers one request, with a random gap in front of it when the phase asks for one, and
    // returns at the edge that accepts it. Valid is only lowered when a gap follows, so a
    // back-to-back request never sees valid dropped and raised within one time step.
    task automatic send_request(t_req kind, logic signed [DATA_W-1:0] value,
                                logic [POS_W-1:0] pos);
        if ($urandom_range(99) < sender_idle_pct) begin
            req_if.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < sender_idle_pct);
        end
        req_if.valid      <= 1'b1;
        req_if.req_type   <= kind;
        req_if.item_value <= value;
        req_if.position   <= pos;
        do @(posedge i_clk); while (!req_if.ready);
        book.note_request(kind, value, pos);
    endtask

    // Draws one random request. Deletes mostly hit a position inside the list; the rest use
    // any 4-bit position, so out-of-range deletes keep coming too.
    task automatic random_request();
        int                       roll;
        int                       push_share;
        t_req                     kind;
        logic signed [DATA_W-1:0] value;
        logic [POS_W-1:0]         pos;
        if ($urandom_range(39) == 0) growing = !growing;
        if (book.fill == CAPACITY && $urandom_range(5) == 0) growing = 1'b0;
        if (book.fill == 0 && $urandom_range(3) == 0) growing = 1'b1;
        push_share = growing ? 70 : 30;

        roll = $urandom_range(99);
        if (roll < push_share) begin
            kind = $urandom_range(1) ? REQ_PUSH_BACK : REQ_PUSH_FRONT;
        end else if (roll < 92) begin
            kind = REQ_DELETE;
        end else begin
            kind = REQ_NOP;
        end

        case ($urandom_range(11))
            0:       value = VAL_MAX;
            1:       value = VAL_MIN;
            2:       value = '0;
            3:       value = '1;
            default: value = $urandom;
        endcase

        if (kind == REQ_DELETE && book.fill > 0 && $urandom_range(9) < 8) begin
            pos = POS_W'($urandom_range(book.fill - 1));
        end else begin
            pos = POS_W'($urandom);
        end
        send_request(kind, value, pos);
    endtask

    initial begin
        book = new();
        growing = 1'b1;
        sender_idle_pct = 0;
        sink_stall_pct  = 0;
        quiet_cycles    = 0;
        req_if.valid      = 1'b0;
        req_if.req_type   = REQ_NOP;
        req_if.item_value = '0;
        req_if.position   = '0;
        dump_if.ready     = 1'b0;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part, with no idling on either side.
        // An empty list: a delete is ignored and both requests dump a single empty beat.
        send_request(REQ_DELETE, '0, 4'd0);
        send_request(REQ_NOP, '1, 4'd15);
        // Extreme values at both ends: the list becomes MIN, MAX, 0.
        send_request(REQ_PUSH_BACK, VAL_MAX, 4'd0);
        send_request(REQ_PUSH_FRONT, VAL_MIN, 4'd15);
        send_request(REQ_PUSH_BACK, '0, 4'd7);
        // A delete past the back is ignored; then a middle delete, a back delete, and the
        // front delete of the only entry left.
        send_request(REQ_DELETE, VAL_MAX, 4'd15);
        send_request(REQ_DELETE, '0, 4'd1);
        send_request(REQ_DELETE, '0, 4'd1);
        send_request(REQ_DELETE, '1, 4'd0);
        // Fill the list from both ends; the front pushes wrap the ring index.
        for (int k = 0; k < CAPACITY; k++) begin
            send_request((k % 2) ? REQ_PUSH_FRONT : REQ_PUSH_BACK,
                         (k == 5) ? '1 : $urandom, POS_W'($urandom));
        end
        // Pushes into the full list are dropped and flagged.
        send_request(REQ_PUSH_FRONT, VAL_MAX, 4'd0);
        send_request(REQ_PUSH_BACK, VAL_MIN, 4'd15);
        // Back delete of a full list, then a middle delete at position 1 of the remaining list.
        send_request(REQ_DELETE, '0, 4'd15);
        send_request(REQ_DELETE, '0, 4'd1);

        // Random part in four idling phases: none, a slow sender, a slow sink, and both
        // idling now and then.
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin sender_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin sender_idle_pct = 66; sink_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  sink_stall_pct = 66; end
                default: begin sender_idle_pct = 7; sink_stall_pct = 7; end
            endcase
            repeat (RANDOM_PER_PHASE) random_request();
        end
        req_if.valid <= 1'b0;

        // Drain every expected beat, then watch a while longer for beats nobody asked for.
        // The watchdog ends the run if the dump stalls.
        while (book.expected_beats.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Ran %0d requests: %0d pushes rejected, %0d deletes ignored, %0d middle.",
                 book.requests, book.rejected_pushes, book.ignored_deletes,
                 book.middle_deletes);
        $display("Checked %0d beats; the list peaked at %0d of %0d entries; %0d mismatches.",
                 book.beats_checked, book.peak_fill, CAPACITY, book.mismatches);
        if (book.mismatches == 0) begin
            $display("deque_indexed_delete_dump_unit regression: pass");
        end else begin
            $display("deque_indexed_delete_dump_unit regression: fail");
        end
        $finish;
    end

endmodule

// File: sim.f
sv/dqd_pkg.sv
sv/dqd_if.sv
sv/deque_indexed_delete_dump_unit.sv
tb/testbench.sv
